### rtl/core/pnd_pkg.sv
// Shared types and constants for the path normalizer.
package pnd_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_ONE_DOT = 2'd1;
    localparam logic [1:0] PH_TWO_DOT = 2'd2;
    localparam logic [1:0] PH_NAME    = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       path_done;
        logic       path_bad;
        logic       run_last;
    } t_out;

    // Work list for one input byte, expanded in this order by the back end.
    typedef struct packed {
        logic       lead;
        logic       sep;
        logic [1:0] ndots;
        logic       emit_c;
        logic [7:0] c;
        logic       term;
        logic       term_bad;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_req;

endpackage

### rtl/core/pnd_front.sv
// Front end: tracks path state per byte and builds the work list for the back end.
module pnd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  pnd_pkg::t_in      i_req,
    output pnd_pkg::t_cmd_req o_cmd
);

    logic       r_started, n_started;
    logic [1:0] r_phase, n_phase;
    logic       r_emitted, n_emitted;
    logic       r_dropping, n_dropping;

    pnd_pkg::t_cmd cmd;
    logic          bad;
    logic          last;
    logic [7:0]    c;

    always_comb begin
        c          = i_req.in_byte;
        last       = i_req.in_last;
        n_started  = r_started;
        n_phase    = r_phase;
        n_emitted  = r_emitted;
        n_dropping = r_dropping;
        bad        = 1'b0;
        cmd        = '0;
        cmd.c      = c;
        if (r_dropping) begin
            if (last) begin
                n_started  = 1'b0;
                n_phase    = pnd_pkg::PH_IDLE;
                n_emitted  = 1'b0;
                n_dropping = 1'b0;
            end
        end else begin
            cmd.lead  = !r_started;
            n_started = 1'b1;
            if (c == pnd_pkg::CH_SLASH) begin
                if (r_phase == pnd_pkg::PH_ONE_DOT || r_phase == pnd_pkg::PH_TWO_DOT) begin
                    bad = 1'b1;
                end else begin
                    n_phase = pnd_pkg::PH_IDLE;
                end
            end else if (r_phase == pnd_pkg::PH_NAME) begin
                cmd.emit_c = 1'b1;
            end else if (c == pnd_pkg::CH_DOT && r_phase != pnd_pkg::PH_TWO_DOT) begin
                n_phase = r_phase + 2'd1;
            end else begin
                cmd.sep    = r_emitted;
                cmd.ndots  = r_phase;
                cmd.emit_c = 1'b1;
                n_emitted  = 1'b1;
                n_phase    = pnd_pkg::PH_NAME;
            end
            if (last && (n_phase == pnd_pkg::PH_ONE_DOT || n_phase == pnd_pkg::PH_TWO_DOT)) begin
                bad = 1'b1;
            end
            cmd.term     = bad || last;
            cmd.term_bad = bad;
            if (last) begin
                n_started  = 1'b0;
                n_phase    = pnd_pkg::PH_IDLE;
                n_emitted  = 1'b0;
                n_dropping = 1'b0;
            end else if (bad) begin
                n_dropping = 1'b1;
            end
        end
    end

    always_comb begin
        o_cmd.cmd   = cmd;
        o_cmd.valid = i_fire && (cmd.lead || cmd.sep || (cmd.ndots != 2'd0)
                                 || cmd.emit_c || cmd.term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_phase    <= pnd_pkg::PH_IDLE;
            r_emitted  <= 1'b0;
            r_dropping <= 1'b0;
        end else if (i_fire) begin
            r_started  <= n_started;
            r_phase    <= n_phase;
            r_emitted  <= n_emitted;
            r_dropping <= n_dropping;
        end
    end

endmodule

### rtl/core/pnd_cmd_fifo.sv
// Short register queue of work lists between front and back ends.
module pnd_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pnd_pkg::t_cmd_req i_push,
    input  logic              i_pop,
    output pnd_pkg::t_cmd_req o_head,
    output logic              o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pnd_pkg::t_cmd   r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

### rtl/core/pnd_back.sv
// Back end: expands each work list into result requests, one per cycle while the output is not stalled.
module pnd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pnd_pkg::t_cmd_req i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output pnd_pkg::t_out     o_req
);

    logic          r_busy, n_busy;
    pnd_pkg::t_cmd r_cmd, n_cmd;
    logic          r_out_valid;
    pnd_pkg::t_out r_out;

    pnd_pkg::t_cmd cur, rem;
    pnd_pkg::t_out item;
    logic          have, load, rem_empty;

    assign cur  = r_busy ? r_cmd : i_head.cmd;
    assign have = r_busy || i_head.valid;
    assign load = have && (!r_out_valid || !i_stall);

    always_comb begin
        rem  = cur;
        item = '0;
        if (cur.lead) begin
            item.out_byte   = pnd_pkg::CH_SLASH;
            item.byte_valid = 1'b1;
            rem.lead        = 1'b0;
        end else if (cur.sep) begin
            item.out_byte   = pnd_pkg::CH_SLASH;
            item.byte_valid = 1'b1;
            rem.sep         = 1'b0;
        end else if (cur.ndots != 2'd0) begin
            item.out_byte   = pnd_pkg::CH_DOT;
            item.byte_valid = 1'b1;
            rem.ndots       = cur.ndots - 2'd1;
        end else if (cur.emit_c) begin
            item.out_byte   = cur.c;
            item.byte_valid = 1'b1;
            rem.emit_c      = 1'b0;
        end else begin
            item.path_done = 1'b1;
            item.path_bad  = cur.term_bad;
            rem.term       = 1'b0;
        end
        rem_empty     = !(rem.lead || rem.sep || (rem.ndots != 2'd0) || rem.emit_c
                          || rem.term);
        item.run_last = rem_empty;
    end

    always_comb begin
        n_busy = r_busy;
        n_cmd  = r_cmd;
        o_pop  = 1'b0;
        if (load) begin
            o_pop  = !r_busy;
            n_busy = !rem_empty;
            n_cmd  = rem;
        end
    end

    assign o_valid = r_out_valid;
    assign o_req   = r_out;

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (load) begin
            r_out <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/path_normalizer_dot_reject_top.sv
// Path normalizer top level: front end, work-list queue and back end.
//
// Input channel: one path byte per request (i_in_req.in_byte, in_last marks
// the final byte of a path), accepted when i_in_valid is high and o_in_stall
// is low. Output channel: result requests on o_out_req, taken when
// o_out_valid is high and i_out_stall is low. Each input byte yields zero to
// five results; run_last flags the last result of a byte, path_done ends a
// path (path_bad set on the error item, after which the path is dropped).
// With the queue and back end idle, the first result of a byte is written
// into the queue and then registered on the output. Throughput: one input
// byte per cycle while the queue has room; the back end delivers one result
// per cycle while the receiver does not stall. The queue of QUEUE_DEPTH work
// lists absorbs bursts of bytes that yield several results; o_in_stall rises
// only when it is full.
// Reset clears path state, the queue and the output register.
// When the receiver stalls, the output request holds and the queue fills.
module path_normalizer_dot_reject_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pnd_pkg::t_in  i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pnd_pkg::t_out o_out_req
);

    pnd_pkg::t_cmd_req push;
    pnd_pkg::t_cmd_req head;
    logic              pop;
    logic              full;
    logic              fire;

    assign o_in_stall = full;
    assign fire       = i_in_valid && !full;

    pnd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (i_in_req),
        .o_cmd   (push)
    );

    pnd_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    pnd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_req   (o_out_req)
    );

endmodule
